// File: rtl/slipd_pkg.sv
// Shared types and constants for the SLIP frame decoder.
// Holds the beat structs, status codes, SLIP byte values and the frame state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slipd_pkg;

	// Default width of the decoded byte counter.
	localparam int unsigned LENGTH_BITS_DEF = 16;

	// Capacity register width and reset value.
	localparam int unsigned CAP_BITS  = 16;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 16'hFFFF;

	// SLIP special bytes: frame end, frame escape and the two transposed codes.
	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;

	// Operation codes carried by an input beat.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_ARM  = 1'b1;

	// Status codes reported with every result beat.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NEED_MORE   = 3'd1;
	localparam logic [2:0] ST_PARSED      = 3'd2;
	localparam logic [2:0] ST_WRONG_STATE = 3'd3;
	localparam logic [2:0] ST_BAD_ESCAPE  = 3'd4;
	localparam logic [2:0] ST_TOO_LONG    = 3'd5;
	localparam logic [2:0] ST_ZERO_CAP    = 3'd6;

	// Framing state, one-hot.
	typedef enum logic [2:0] {
		FR_HUNT    = 3'b001,  // looking for the first END
		FR_OPEN    = 3'b010,  // next byte may be an opening END
		FR_STARTED = 3'b100   // inside a message
	} frame_t;

	// Control state of the decoder.
	typedef struct packed {
		frame_t frame;
		logic   escape;
		logic   armed;
	} ctl_t;

	// Input beat.
	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [2:0]  status;
		logic        write_valid;
		logic [7:0]  write_data;
		logic [15:0] write_index;
		logic [15:0] message_length;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/slipd_step.sv
// One decode step of the SLIP frame decoder: next control state, next count and result.
// Purely combinational; depends on slipd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slipd_step #(
	parameter int unsigned LENGTH_BITS = slipd_pkg::LENGTH_BITS_DEF
) (
	input  slipd_pkg::item_t                    item,
	input  slipd_pkg::ctl_t                     cur,
	input  logic [LENGTH_BITS-1:0]              count,
	input  logic [slipd_pkg::CAP_BITS-1:0]      capacity,
	output slipd_pkg::ctl_t                     nxt,
	output logic [LENGTH_BITS-1:0]              count_nxt,
	output slipd_pkg::result_t                  result
);

	// Common width for comparing the count with the capacity register.
	localparam int unsigned CW = (LENGTH_BITS > slipd_pkg::CAP_BITS) ?
		LENGTH_BITS : slipd_pkg::CAP_BITS;

	logic [CW-1:0] count_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] cap_w;
	logic          full;
	logic          is_end;
	logic          app_write;
	logic          app_err;
	logic          app_esc;
	logic [7:0]    app_data;
	logic [2:0]    app_status;

	// The count may not pass the capacity, nor the all-ones value of the counter.
	assign count_w = CW'(count);
	assign cap_w   = CW'(capacity);
	assign full    = (count_w >= cap_w) || (&count);
	assign is_end  = (item.rx_byte == slipd_pkg::FEND);

	// Unescape one byte and check it against the capacity.
	always_comb begin
		app_write  = 1'b0;
		app_err    = 1'b0;
		app_esc    = cur.escape;
		app_data   = item.rx_byte;
		app_status = slipd_pkg::ST_OK;
		if (cur.escape) begin
			if (item.rx_byte == slipd_pkg::TFESC) begin
				app_data  = slipd_pkg::FESC;
				app_write = 1'b1;
				app_esc   = 1'b0;
			end else if (item.rx_byte == slipd_pkg::TFEND) begin
				app_data  = slipd_pkg::FEND;
				app_write = 1'b1;
				app_esc   = 1'b0;
			end else begin
				app_err    = 1'b1;
				app_status = slipd_pkg::ST_BAD_ESCAPE;
			end
		end else if (item.rx_byte == slipd_pkg::FESC) begin
			app_esc = 1'b1;
		end else begin
			app_write = 1'b1;
		end
		if (app_write && full) begin
			app_write  = 1'b0;
			app_err    = 1'b1;
			app_status = slipd_pkg::ST_TOO_LONG;
		end
	end

	// Main decision on the operation and the framing state.
	always_comb begin
		nxt                = cur;
		count_nxt          = count;
		result.status      = slipd_pkg::ST_NEED_MORE;
		result.write_valid = 1'b0;
		result.write_data  = 8'd0;
		result.write_index = 16'd0;
		if (item.operation == slipd_pkg::OP_ARM) begin
			if (capacity == '0) begin
				result.status = slipd_pkg::ST_ZERO_CAP;
			end else begin
				nxt.armed     = 1'b1;
				count_nxt     = '0;
				result.status = slipd_pkg::ST_OK;
			end
		end else if (!cur.armed) begin
			result.status = slipd_pkg::ST_WRONG_STATE;
		end else begin
			case (cur.frame)
				slipd_pkg::FR_OPEN: begin
					// An opening END is dropped; anything else goes to the buffer.
					if (is_end) begin
						nxt.frame = slipd_pkg::FR_STARTED;
					end else if (app_err) begin
						result.status = app_status;
					end else begin
						nxt.frame  = slipd_pkg::FR_STARTED;
						nxt.escape = app_esc;
					end
				end
				slipd_pkg::FR_STARTED: begin
					// A closing END completes the message.
					if (is_end) begin
						nxt.frame     = slipd_pkg::FR_OPEN;
						nxt.armed     = 1'b0;
						nxt.escape    = 1'b0;
						result.status = slipd_pkg::ST_PARSED;
					end else if (app_err) begin
						result.status = app_status;
					end else begin
						nxt.escape = app_esc;
					end
				end
				default: begin
					nxt.frame = is_end ? slipd_pkg::FR_OPEN : slipd_pkg::FR_HUNT;
				end
			endcase
			// Any fault ends the message and sends the decoder back to hunting.
			if (app_err && !is_end && (cur.frame == slipd_pkg::FR_OPEN ||
					cur.frame == slipd_pkg::FR_STARTED)) begin
				nxt.frame  = slipd_pkg::FR_HUNT;
				nxt.armed  = 1'b0;
				nxt.escape = 1'b0;
			end
			// Emit the decoded byte with its position.
			if (app_write && !is_end && (cur.frame == slipd_pkg::FR_OPEN ||
					cur.frame == slipd_pkg::FR_STARTED)) begin
				result.write_valid = 1'b1;
				result.write_data  = app_data;
				result.write_index = count_w[15:0];
				count_nxt          = count + LENGTH_BITS'(1);
			end
		end
		// The length reported is the count after this beat.
		len_w                 = CW'(count_nxt);
		result.message_length = len_w[15:0];
	end

endmodule
`default_nettype wire

// File: rtl/slip_frame_decoder.sv
// Top level of the SLIP frame decoder: input register, decode step and result register.
// Depends on slipd_pkg and slipd_step.
`timescale 1ns / 1ps
`default_nettype none
// The decoder takes one beat per clock cycle while it is not stalled: either a command to arm
// a new message or one raw byte from the serial link, and gives exactly one result beat for
// each. A beat is registered in the input register, decoded by a short combinational step
// against the framing state and the byte count, and the result lands in the output register,
// from which it can be taken; a new beat can be taken every cycle while the result side keeps
// up. The result register frees itself in the same cycle that its beat is taken, so stall on
// the result side reaches the input stall only when both registers are full. The capacity
// register is written through the cfg channel, which is always ready; it should only be
// written while no beat is in flight.
module slip_frame_decoder #(
	parameter int unsigned LENGTH_BITS = slipd_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  slipd_pkg::item_t                  item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output slipd_pkg::result_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slipd_pkg::CAP_BITS-1:0]    cfg_data
);

	slipd_pkg::item_t                 item_s1;
	logic                             valid_s1;
	slipd_pkg::result_t               result_s2;
	logic                             valid_s2;
	slipd_pkg::ctl_t                  ctl_q;
	slipd_pkg::ctl_t                  ctl_nxt;
	logic [LENGTH_BITS-1:0]           count_q;
	logic [LENGTH_BITS-1:0]           count_nxt;
	logic [slipd_pkg::CAP_BITS-1:0]   capacity_q;
	slipd_pkg::result_t               step_result;
	logic                             s2_free;
	logic                             s1_free;
	logic                             advance;

	// Flow control between the two register stages.
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign item_stall = !s1_free;
	assign cfg_ready  = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= slipd_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid) begin
			item_s1 <= item;
		end
	end

	// Decode step.
	slipd_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.item      (item_s1),
		.cur       (ctl_q),
		.count     (count_q),
		.capacity  (capacity_q),
		.nxt       (ctl_nxt),
		.count_nxt (count_nxt),
		.result    (step_result)
	);

	// Decoder state moves on once per decoded beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.frame  <= slipd_pkg::FR_HUNT;
			ctl_q.escape <= 1'b0;
			ctl_q.armed  <= 1'b0;
			count_q      <= '0;
		end else if (advance) begin
			ctl_q   <= ctl_nxt;
			count_q <= count_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the SLIP frame decoder: directed table, then random frames.
// Depends on slipd_pkg and slip_frame_decoder; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb;

	localparam int QUIET_LIMIT = 1000;

	// One row of the directed table: either a capacity write or an input beat.
	typedef struct {
		logic               is_cap;
		logic [15:0]        cap;
		slipd_pkg::item_t   beat;
		logic               known;
		slipd_pkg::result_t res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	slipd_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	slipd_pkg::result_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        cfg_data;

	// Predictor state, a private copy of the decoder's framing state and capacity.
	slipd_pkg::frame_t  dec_frame;
	logic               dec_escape;
	logic               dec_armed;
	logic [15:0]        dec_count;
	logic [15:0]        dec_capacity;

	slipd_pkg::result_t expected_results[$];
	slipd_pkg::result_t next_expected;
	dir_row_t           dir_table[$];
	logic [15:0]        cap_plan[9];
	int                 mismatch_count;
	int                 results_seen;
	int                 quiet_cycles;
	int                 tx_idle_pct;
	int                 rx_idle_pct;

	slip_frame_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	// An error ends the message and sends the framer back to hunting.
	function automatic void abort_message();
		dec_armed  = 1'b0;
		dec_escape = 1'b0;
		dec_frame  = slipd_pkg::FR_HUNT;
	endfunction

	// Undo an escape if one is pending and append the byte, within the capacity.
	function automatic logic [2:0] append_decoded(input logic [7:0] b,
			inout slipd_pkg::result_t r);
		logic [7:0] outb;
		if (dec_escape) begin
			if (b == slipd_pkg::TFESC) begin
				outb = slipd_pkg::FESC;
			end else if (b == slipd_pkg::TFEND) begin
				outb = slipd_pkg::FEND;
			end else begin
				abort_message();
				return slipd_pkg::ST_BAD_ESCAPE;
			end
			dec_escape = 1'b0;
		end else if (b == slipd_pkg::FESC) begin
			dec_escape = 1'b1;
			return slipd_pkg::ST_OK;
		end else begin
			outb = b;
		end
		if (int'(dec_count) + 1 > int'(dec_capacity)) begin
			abort_message();
			return slipd_pkg::ST_TOO_LONG;
		end
		r.write_valid = 1'b1;
		r.write_data  = outb;
		r.write_index = dec_count;
		dec_count     = dec_count + 16'd1;
		return slipd_pkg::ST_OK;
	endfunction

	// Works out the result beat for one accepted input beat and advances the state.
	function automatic slipd_pkg::result_t predict_decode(input slipd_pkg::item_t it);
		slipd_pkg::result_t r;
		logic [2:0]         s;
		r = '0;
		if (it.operation == slipd_pkg::OP_ARM) begin
			if (dec_capacity == 16'd0) begin
				r.status = slipd_pkg::ST_ZERO_CAP;
			end else begin
				dec_armed = 1'b1;
				dec_count = 16'd0;
				r.status  = slipd_pkg::ST_OK;
			end
		end else if (!dec_armed) begin
			r.status = slipd_pkg::ST_WRONG_STATE;
		end else begin
			case (dec_frame)
				slipd_pkg::FR_OPEN: begin
					r.status = slipd_pkg::ST_NEED_MORE;
					if (it.rx_byte != slipd_pkg::FEND) begin
						s = append_decoded(it.rx_byte, r);
						if (s != slipd_pkg::ST_OK)
							r.status = s;
					end
					if (r.status == slipd_pkg::ST_NEED_MORE)
						dec_frame = slipd_pkg::FR_STARTED;
				end
				slipd_pkg::FR_STARTED: begin
					if (it.rx_byte == slipd_pkg::FEND) begin
						dec_frame  = slipd_pkg::FR_OPEN;
						dec_armed  = 1'b0;
						dec_escape = 1'b0;
						r.status   = slipd_pkg::ST_PARSED;
					end else begin
						s = append_decoded(it.rx_byte, r);
						r.status = (s != slipd_pkg::ST_OK) ? s : slipd_pkg::ST_NEED_MORE;
					end
				end
				default: begin
					dec_frame = (it.rx_byte == slipd_pkg::FEND) ?
							slipd_pkg::FR_OPEN : slipd_pkg::FR_HUNT;
					r.status  = slipd_pkg::ST_NEED_MORE;
				end
			endcase
		end
		r.message_length = dec_count;
		return r;
	endfunction

	function automatic slipd_pkg::item_t make_beat(input logic op, input logic [7:0] b);
		slipd_pkg::item_t it;
		it.operation = op;
		it.rx_byte   = b;
		return it;
	endfunction

	function automatic dir_row_t item_row(input logic op, input logic [7:0] b);
		dir_row_t row;
		row        = '{is_cap: 1'b0, cap: 16'd0, beat: make_beat(op, b), known: 1'b0,
				res: '0};
		return row;
	endfunction

	function automatic dir_row_t known_row(input logic op, input logic [7:0] b,
			input logic [2:0] st, input logic wv, input logic [7:0] wd,
			input logic [15:0] wi, input logic [15:0] len);
		dir_row_t row;
		row           = item_row(op, b);
		row.known     = 1'b1;
		row.res       = '{status: st, write_valid: wv, write_data: wd, write_index: wi,
				message_length: len};
		return row;
	endfunction

	function automatic dir_row_t cap_row(input logic [15:0] v);
		dir_row_t row;
		row        = item_row(slipd_pkg::OP_BYTE, 8'h00);
		row.is_cap = 1'b1;
		row.cap    = v;
		return row;
	endfunction

	// Offer one beat after a random gap, wait for it to be taken and queue its result.
	task automatic send_item(input slipd_pkg::item_t it, input logic known,
			input slipd_pkg::result_t known_res);
		slipd_pkg::result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		predicted = predict_decode(it);
		expected_results.push_back(known ? known_res : predicted);
	endtask

	task automatic send_raw(input logic op, input logic [7:0] b);
		send_item(make_beat(op, b), 1'b0, '0);
	endtask

	// The capacity is written only once every outstanding result has come back.
	task automatic set_capacity(input logic [15:0] v);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		dec_capacity = v;
		@(posedge clk);
	endtask

	// Raw byte biased towards the SLIP special values.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return slipd_pkg::FEND;
			1: return slipd_pkg::FESC;
			2: return slipd_pkg::TFEND;
			3: return slipd_pkg::TFESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed frames with random content; the rest is noise and broken frames.
	task automatic send_random_sequence(inout int sent);
		int         n;
		logic [7:0] b;
		if ($urandom_range(0, 99) < 72) begin
			send_raw(slipd_pkg::OP_ARM, 8'h00);
			sent++;
			if ($urandom_range(0, 9) < 8) begin
				send_raw(slipd_pkg::OP_BYTE, slipd_pkg::FEND);
				sent++;
			end
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			repeat (n) begin
				b = pick_byte();
				if (b == slipd_pkg::FEND) begin
					send_raw(slipd_pkg::OP_BYTE, slipd_pkg::FESC);
					send_raw(slipd_pkg::OP_BYTE, slipd_pkg::TFEND);
					sent += 2;
				end else if (b == slipd_pkg::FESC) begin
					send_raw(slipd_pkg::OP_BYTE, slipd_pkg::FESC);
					send_raw(slipd_pkg::OP_BYTE, slipd_pkg::TFESC);
					sent += 2;
				end else begin
					send_raw(slipd_pkg::OP_BYTE, b);
					sent++;
				end
			end
			// Now and then the closing END is left off, so the next arm cuts in.
			if ($urandom_range(0, 9) != 0) begin
				send_raw(slipd_pkg::OP_BYTE, slipd_pkg::FEND);
				sent++;
			end
		end else begin
			repeat ($urandom_range(1, 8)) begin
				send_raw(($urandom_range(0, 7) == 0) ? slipd_pkg::OP_ARM : slipd_pkg::OP_BYTE,
						($urandom_range(0, 3) == 0) ? slipd_pkg::FESC : pick_byte());
				sent++;
			end
		end
	endtask

	// Result side: random stall, checking against the oldest expectation, and the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", result));
				end else begin
					next_expected = expected_results.pop_front();
					if (result.status !== next_expected.status)
						report_mismatch($sformatf("status got %0d want %0d",
								result.status, next_expected.status));
					if (result.write_valid !== next_expected.write_valid)
						report_mismatch($sformatf("write_valid got %b want %b",
								result.write_valid, next_expected.write_valid));
					if (result.write_data !== next_expected.write_data)
						report_mismatch($sformatf("write_data got %h want %h",
								result.write_data, next_expected.write_data));
					if (result.write_index !== next_expected.write_index)
						report_mismatch($sformatf("write_index got %0d want %0d",
								result.write_index, next_expected.write_index));
					if (result.message_length !== next_expected.message_length)
						report_mismatch($sformatf("message_length got %0d want %0d",
								result.message_length, next_expected.message_length));
				end
			end
			result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL slip_frame_decoder");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus: reset, directed table, then random frames under three idling patterns.
	initial begin
		int sent;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		mismatch_count = 0;
		results_seen   = 0;
		tx_idle_pct    = 26;
		rx_idle_pct    = 56;
		dec_frame      = slipd_pkg::FR_HUNT;
		dec_escape     = 1'b0;
		dec_armed      = 1'b0;
		dec_count      = 16'd0;
		dec_capacity   = slipd_pkg::CAP_RESET;

		// Reset state, hunting, the opening END, both escapes and a clean close.
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h00, slipd_pkg::ST_WRONG_STATE,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(known_row(slipd_pkg::OP_ARM, 8'hFF, slipd_pkg::ST_OK,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h55, slipd_pkg::ST_NEED_MORE,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, slipd_pkg::FEND,
				slipd_pkg::ST_NEED_MORE, 1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, slipd_pkg::FEND,
				slipd_pkg::ST_NEED_MORE, 1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, 8'h00));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, 8'hFF));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::FESC));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::TFEND));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::FESC));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::TFESC));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, slipd_pkg::FEND,
				slipd_pkg::ST_PARSED, 1'b0, 8'h00, 16'd0, 16'd4));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h11, slipd_pkg::ST_WRONG_STATE,
				1'b0, 8'h00, 16'd0, 16'd4));
		// Escape followed by an illegal byte.
		dir_table.push_back(known_row(slipd_pkg::OP_ARM, 8'h00, slipd_pkg::ST_OK,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::FESC));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h41, slipd_pkg::ST_BAD_ESCAPE,
				1'b0, 8'h00, 16'd0, 16'd0));
		// Back from hunting; an escape code byte outside an escape is plain data.
		dir_table.push_back(known_row(slipd_pkg::OP_ARM, 8'h00, slipd_pkg::ST_OK,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::TFEND));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::FEND));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, slipd_pkg::TFEND));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, slipd_pkg::FEND,
				slipd_pkg::ST_PARSED, 1'b0, 8'h00, 16'd0, 16'd1));
		// Zero capacity refuses to arm.
		dir_table.push_back(cap_row(16'd0));
		dir_table.push_back(known_row(slipd_pkg::OP_ARM, 8'h00, slipd_pkg::ST_ZERO_CAP,
				1'b0, 8'h00, 16'd0, 16'd1));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h00, slipd_pkg::ST_WRONG_STATE,
				1'b0, 8'h00, 16'd0, 16'd1));
		// Capacity of one: the second byte overflows.
		dir_table.push_back(cap_row(16'd1));
		dir_table.push_back(known_row(slipd_pkg::OP_ARM, 8'h00, slipd_pkg::ST_OK,
				1'b0, 8'h00, 16'd0, 16'd0));
		dir_table.push_back(item_row(slipd_pkg::OP_BYTE, 8'h7E));
		dir_table.push_back(known_row(slipd_pkg::OP_BYTE, 8'h80, slipd_pkg::ST_TOO_LONG,
				1'b0, 8'h00, 16'd0, 16'd1));
		dir_table.push_back(cap_row(16'hFFFF));

		cap_plan = '{16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd16, 16'd2,
				16'($urandom_range(0, 65535)), 16'd8, 16'd5};

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].is_cap)
				set_capacity(dir_table[i].cap);
			else
				send_item(dir_table[i].beat, dir_table[i].known, dir_table[i].res);
		end

		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 56 : 0;
			rx_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 26 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				set_capacity(cap_plan[mode * 3 + blk]);
				sent = 0;
				while (sent < 70)
					send_random_sequence(sent);
			end
		end

		// Drain, then let the pipeline run on idle to show anything stray.
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("PASS slip_frame_decoder");
		else
			$display("FAIL slip_frame_decoder");
		$finish;
	end

endmodule
